// ----- src/tcce_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

	localparam int CELLS_DEFAULT = 4096;

	// offset width: holds any row * columns + column or walk index, and CELLS itself
	localparam int IW = 15;

	localparam int CHAR_W = 8;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] REG_COLUMNS = 2'd0;
	localparam logic [1:0] REG_ROWS    = 2'd1;
	localparam logic [1:0] REG_ATTR    = 2'd2;

	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;

	localparam logic [7:0] COLS_RESET = 8'd80;
	localparam logic [7:0] COLS_MAX   = 8'd128;
	localparam logic [5:0] ROWS_RESET = 6'd25;
	localparam logic [5:0] ROWS_MAX   = 6'd32;
	localparam logic [7:0] ATTR_RESET = 8'd3;

	// clamped screen geometry and current attribute
	typedef struct packed {
		logic [7:0] cols;
		logic [5:0] rows;
		logic [7:0] attr;
	} cfg_t;

	// one write to the character and attribute stores, shared address
	typedef struct packed {
		logic              char_we;
		logic              attr_we;
		logic [IW-1:0]     addr;
		logic [CHAR_W-1:0] char_d;
		logic [CHAR_W-1:0] attr_d;
	} mem_wr_t;

endpackage

`default_nettype wire

// ----- src/tcce_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcce_ram #(
	parameter int DEPTH = tcce_pkg::CELLS_DEFAULT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [tcce_pkg::CHAR_W-1:0] wdata,
	input  wire logic [AW-1:0]               raddr,
	output logic      [tcce_pkg::CHAR_W-1:0] rdata
);

	logic [tcce_pkg::CHAR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- src/tcce_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none

// row * columns + column; also gives rows * columns and index + columns
module tcce_mac (
	input  wire logic [5:0]             row_in,
	input  wire logic [tcce_pkg::IW-1:0] col_in,
	input  wire logic [7:0]             cols,
	output logic      [tcce_pkg::IW-1:0] sum
);

	logic [13:0] prod;

	assign prod = row_in * cols;
	assign sum  = {1'b0, prod} + col_in;

endmodule

`default_nettype wire

// ----- src/tcce_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcce_ctrl #(
	parameter int CELLS = tcce_pkg::CELLS_DEFAULT
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire tcce_pkg::cfg_t          cfg,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [1:0]              in_op,
	input  wire logic [7:0]              in_char,
	input  wire logic [11:0]             in_idx,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [11:0]                  out_offset,
	output logic                         out_scrolled,
	output logic [7:0]                   out_char,
	output logic [7:0]                   out_attr,
	output tcce_pkg::mem_wr_t            mem_wr,
	output logic [tcce_pkg::IW-1:0]      rd_addr,
	input  wire logic [7:0]              char_rd,
	input  wire logic [7:0]              attr_rd
);

	localparam int IW = tcce_pkg::IW;
	localparam logic [IW-1:0] CELLS_W   = IW'(CELLS);
	localparam logic [IW-1:0] LAST_CELL = IW'(CELLS - 1);

	localparam logic [3:0] ST_INIT    = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_START   = 4'd2;
	localparam logic [3:0] ST_PUT     = 4'd3;
	localparam logic [3:0] ST_MOVE    = 4'd4;
	localparam logic [3:0] ST_SCROLL  = 4'd5;
	localparam logic [3:0] ST_SCR_END = 4'd6;
	localparam logic [3:0] ST_LAND_A  = 4'd7;
	localparam logic [3:0] ST_LAND_B  = 4'd8;
	localparam logic [3:0] ST_PRINT   = 4'd9;
	localparam logic [3:0] ST_BS_WR   = 4'd10;
	localparam logic [3:0] ST_CLEAR   = 4'd11;
	localparam logic [3:0] ST_READ_A  = 4'd12;
	localparam logic [3:0] ST_READ_B  = 4'd13;
	localparam logic [3:0] ST_DONE    = 4'd14;

	// where a cursor move returns to
	localparam logic [1:0] CONT_DONE = 2'd0;
	localparam logic [1:0] CONT_BS   = 2'd1;
	localparam logic [1:0] CONT_WRAP = 2'd2;

	logic [3:0]    state_q;
	logic [1:0]    op_q;
	logic [7:0]    ch_q;
	logic [11:0]   idx_q;
	logic [7:0]    col_q;
	logic [4:0]    row_q;
	logic [7:0]    mv_col_q;
	logic [5:0]    mv_row_q;
	logic [12:0]   total_q;
	logic [IW-1:0] i_q;
	logic [1:0]    cont_q;
	logic          sc_q;
	logic [7:0]    rc_q;
	logic [7:0]    ra_q;
	logic [IW-1:0] off_q;
	logic          scr_v_s1;
	logic [IW-1:0] scr_dst_s1;
	logic          scr_ok_s1;

	logic [5:0]    mac_row;
	logic [IW-1:0] mac_col;
	logic [IW-1:0] mac_sum;
	logic [IW-1:0] total_w;
	logic [IW-1:0] last_i;
	logic [5:0]    rows_m1;
	logic          mac_in_cells;
	logic          off_in_cells;
	logic          idx_in_cells;

	always_comb begin
		mac_row = '0;
		mac_col = '0;
		unique case (state_q) inside
			ST_START: begin
				mac_row = cfg.rows;
			end
			ST_MOVE: begin
				mac_row = mv_row_q;
				mac_col = IW'(mv_col_q);
			end
			ST_SCROLL: begin
				// source cell one row below
				mac_row = 6'd1;
				mac_col = i_q;
			end
			ST_LAND_A, ST_PRINT, ST_BS_WR, ST_DONE: begin
				mac_row = {1'b0, row_q};
				mac_col = IW'(col_q);
			end
			default: ;
		endcase
	end

	tcce_mac u_mac (
		.row_in (mac_row),
		.col_in (mac_col),
		.cols   (cfg.cols),
		.sum    (mac_sum)
	);

	assign total_w      = IW'(total_q);
	assign last_i       = total_w - IW'(1);
	assign rows_m1      = cfg.rows - 6'd1;
	assign mac_in_cells = mac_sum < CELLS_W;
	assign off_in_cells = off_q < CELLS_W;
	assign idx_in_cells = IW'(idx_q) < CELLS_W;
	assign in_ready     = (state_q == ST_IDLE);

	always_comb begin
		mem_wr  = '0;
		rd_addr = mac_sum;
		// scroll write stage, in the cycle after its read
		if (scr_v_s1) begin
			mem_wr.char_we = scr_dst_s1 < CELLS_W;
			mem_wr.attr_we = scr_dst_s1 < CELLS_W;
			mem_wr.addr    = scr_dst_s1;
			mem_wr.char_d  = scr_ok_s1 ? char_rd : '0;
			mem_wr.attr_d  = scr_ok_s1 ? attr_rd : '0;
		end
		unique case (state_q)
			ST_INIT: begin
				mem_wr.char_we = 1'b1;
				mem_wr.attr_we = 1'b1;
				mem_wr.addr    = i_q;
			end
			ST_CLEAR: begin
				mem_wr.char_we = i_q < CELLS_W;
				mem_wr.attr_we = i_q < CELLS_W;
				mem_wr.addr    = i_q;
				mem_wr.attr_d  = cfg.attr;
			end
			ST_LAND_B: begin
				mem_wr.attr_we = off_in_cells && (char_rd == 8'd0);
				mem_wr.addr    = off_q;
				mem_wr.attr_d  = cfg.attr;
			end
			ST_PRINT: begin
				mem_wr.char_we = mac_in_cells;
				mem_wr.attr_we = mac_in_cells;
				mem_wr.addr    = mac_sum;
				mem_wr.char_d  = ch_q;
				mem_wr.attr_d  = cfg.attr;
			end
			ST_BS_WR: begin
				mem_wr.char_we = mac_in_cells;
				mem_wr.addr    = mac_sum;
			end
			ST_READ_A: begin
				rd_addr = IW'(idx_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			op_q         <= '0;
			ch_q         <= '0;
			idx_q        <= '0;
			col_q        <= '0;
			row_q        <= '0;
			mv_col_q     <= '0;
			mv_row_q     <= '0;
			total_q      <= '0;
			i_q          <= '0;
			cont_q       <= CONT_DONE;
			sc_q         <= 1'b0;
			rc_q         <= '0;
			ra_q         <= '0;
			off_q        <= '0;
			scr_v_s1     <= 1'b0;
			scr_dst_s1   <= '0;
			scr_ok_s1    <= 1'b0;
			out_valid    <= 1'b0;
			out_offset   <= '0;
			out_scrolled <= 1'b0;
			out_char     <= '0;
			out_attr     <= '0;
		end else begin
			scr_v_s1 <= (state_q == ST_SCROLL);
			// in ST_DONE the result register is reloaded below instead
			if (out_valid && out_ready && state_q != ST_DONE) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					if (i_q == LAST_CELL) begin
						state_q <= ST_IDLE;
					end else begin
						i_q <= i_q + IW'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= in_op;
						ch_q    <= in_char;
						idx_q   <= in_idx;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					total_q <= mac_sum[12:0];
					sc_q    <= 1'b0;
					rc_q    <= '0;
					ra_q    <= '0;
					i_q     <= '0;
					unique case (op_q)
						tcce_pkg::OP_PUT:   state_q <= ST_PUT;
						tcce_pkg::OP_CLEAR: state_q <= ST_CLEAR;
						tcce_pkg::OP_READ:  state_q <= ST_READ_A;
						default:            state_q <= ST_DONE;
					endcase
				end
				ST_PUT: begin
					if (ch_q == tcce_pkg::CH_BACKSPACE) begin
						cont_q  <= CONT_BS;
						state_q <= ST_MOVE;
						if (col_q != 8'd0) begin
							mv_col_q <= col_q - 8'd1;
							mv_row_q <= {1'b0, row_q};
						end else if (row_q != 5'd0) begin
							// wrap back to the end of the previous row
							mv_col_q <= cfg.cols - 8'd1;
							mv_row_q <= {1'b0, row_q} - 6'd1;
						end else begin
							mv_col_q <= '0;
							mv_row_q <= '0;
						end
					end else if (col_q >= cfg.cols || ch_q == tcce_pkg::CH_NEWLINE) begin
						mv_col_q <= '0;
						mv_row_q <= {1'b0, row_q} + 6'd1;
						cont_q   <= CONT_WRAP;
						state_q  <= ST_MOVE;
					end else begin
						state_q <= ST_PRINT;
					end
				end
				ST_MOVE: begin
					if (mac_sum >= total_w) begin
						sc_q    <= 1'b1;
						i_q     <= '0;
						state_q <= ST_SCROLL;
					end else begin
						col_q   <= mv_col_q;
						row_q   <= mv_row_q[4:0];
						state_q <= ST_LAND_A;
					end
				end
				ST_SCROLL: begin
					// cells with no source below get blanked
					scr_dst_s1 <= i_q;
					scr_ok_s1  <= (mac_sum < total_w) && mac_in_cells;
					if (i_q == last_i) begin
						state_q <= ST_SCR_END;
					end else begin
						i_q <= i_q + IW'(1);
					end
				end
				ST_SCR_END: begin
					col_q   <= '0;
					row_q   <= rows_m1[4:0];
					state_q <= ST_LAND_A;
				end
				ST_LAND_A: begin
					off_q   <= mac_sum;
					state_q <= ST_LAND_B;
				end
				ST_LAND_B: begin
					unique case (cont_q)
						CONT_BS:   state_q <= ST_BS_WR;
						CONT_WRAP: begin
							state_q <= (ch_q == tcce_pkg::CH_NEWLINE) ? ST_DONE : ST_PRINT;
						end
						default:   state_q <= ST_DONE;
					endcase
				end
				ST_PRINT: begin
					mv_col_q <= col_q + 8'd1;
					mv_row_q <= {1'b0, row_q};
					cont_q   <= CONT_DONE;
					state_q  <= ST_MOVE;
				end
				ST_BS_WR: begin
					state_q <= ST_DONE;
				end
				ST_CLEAR: begin
					if (i_q == last_i) begin
						mv_col_q <= '0;
						mv_row_q <= '0;
						cont_q   <= CONT_DONE;
						state_q  <= ST_MOVE;
					end else begin
						i_q <= i_q + IW'(1);
					end
				end
				ST_READ_A: begin
					state_q <= ST_READ_B;
				end
				ST_READ_B: begin
					rc_q    <= idx_in_cells ? char_rd : 8'd0;
					ra_q    <= idx_in_cells ? attr_rd : 8'd0;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid    <= 1'b1;
						out_offset   <= mac_sum[11:0];
						out_scrolled <= sc_q;
						out_char     <= rc_q;
						out_attr     <= ra_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/text_console_character_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

// A clear walks all rows*columns cells. A scroll walks rows*columns cells too,
// one cell per cycle through the store's single read and write port.
// One item at a time; the next beat is taken in the cycle after the result is registered.
// Reset is asynchronous, active low; afterwards a clearing pass over all CELLS cells zeroes
// the stores with the input held not ready; configuration writes are taken throughout.
module text_console_character_engine #(
	parameter int CELLS = tcce_pkg::CELLS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // char_code[7:0], cell_index[19:8], zero pad
	input  wire logic [1:0]  s_axis_tuser,  // operation[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // cursor_offset[11:0], scrolled[12],
	                                        // cell_char[20:13], cell_attr[28:21], zero pad
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	localparam int AW = $clog2(CELLS);

	logic [7:0] cols_q;
	logic [5:0] rows_q;
	logic [7:0] attr_q;
	logic [7:0] cols_clamp;
	logic [5:0] rows_clamp;

	tcce_pkg::cfg_t    cfg;
	tcce_pkg::mem_wr_t mem_wr;

	logic [tcce_pkg::IW-1:0] rd_addr;
	logic [7:0]              char_rd;
	logic [7:0]              attr_rd;
	logic [11:0]             out_offset;
	logic                    out_scrolled;
	logic [7:0]              out_char;
	logic [7:0]              out_attr;

	assign cfg_ready = 1'b1;

	assign cols_clamp = (cfg_data == 8'd0) ? 8'd1 :
	                    (cfg_data > tcce_pkg::COLS_MAX) ? tcce_pkg::COLS_MAX : cfg_data;
	assign rows_clamp = (cfg_data[5:0] == 6'd0) ? 6'd1 :
	                    (cfg_data[5:0] > tcce_pkg::ROWS_MAX) ? tcce_pkg::ROWS_MAX : cfg_data[5:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= tcce_pkg::COLS_RESET;
			rows_q <= tcce_pkg::ROWS_RESET;
			attr_q <= tcce_pkg::ATTR_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tcce_pkg::REG_COLUMNS: cols_q <= cols_clamp;
				tcce_pkg::REG_ROWS:    rows_q <= rows_clamp;
				tcce_pkg::REG_ATTR:    attr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.cols = cols_q;
	assign cfg.rows = rows_q;
	assign cfg.attr = attr_q;

	tcce_ctrl #(
		.CELLS (CELLS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_op        (s_axis_tuser),
		.in_char      (s_axis_tdata[7:0]),
		.in_idx       (s_axis_tdata[19:8]),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_offset   (out_offset),
		.out_scrolled (out_scrolled),
		.out_char     (out_char),
		.out_attr     (out_attr),
		.mem_wr       (mem_wr),
		.rd_addr      (rd_addr),
		.char_rd      (char_rd),
		.attr_rd      (attr_rd)
	);

	assign m_axis_tdata = {3'b000, out_attr, out_char, out_scrolled, out_offset};

	tcce_ram #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_char_ram (
		.clk   (clk),
		.we    (mem_wr.char_we),
		.waddr (mem_wr.addr[AW-1:0]),
		.wdata (mem_wr.char_d),
		.raddr (rd_addr[AW-1:0]),
		.rdata (char_rd)
	);

	tcce_ram #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_attr_ram (
		.clk   (clk),
		.we    (mem_wr.attr_we),
		.waddr (mem_wr.addr[AW-1:0]),
		.wdata (mem_wr.attr_d),
		.raddr (rd_addr[AW-1:0]),
		.rdata (attr_rd)
	);

endmodule

`default_nettype wire
